>>> rtl/streaming_separable_downscaler_core_macros.svh
// Assertion macros for the streaming separable downscaler.
// Depends on nothing; included by the top level.
`ifndef STREAMING_SEPARABLE_DOWNSCALER_CORE_MACROS_SVH
`define STREAMING_SEPARABLE_DOWNSCALER_CORE_MACROS_SVH

// The condition must never hold outside reset.
`define SSD_ASSERT_NEVER(lbl, clk_s, rst_s, cond, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) !(cond)) else $error(msg);

// The antecedent implies the consequent in the same cycle.
`define SSD_ASSERT_IMPLY(lbl, clk_s, rst_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) else $error(msg);

`endif

>>> rtl/ssd_pkg.sv
// Shared types, constants and arithmetic helpers of the downscaler.
// Depends on nothing; imported by every module of the block.
package ssd_pkg;

    localparam int MAX_OUT_WIDTH = 4096;
    localparam int TAPS          = 4;
    localparam int NCH           = 4;
    localparam int W_FRAC        = 14;
    localparam int COL_W         = $clog2(MAX_OUT_WIDTH);
    localparam int WID_W         = COL_W + 1;
    localparam int TAP_W         = $clog2(TAPS);
    localparam int PROD_W        = 32 + 16;
    localparam int SH_W          = PROD_W - W_FRAC;
    localparam int ROW_W         = 32 * NCH;
    localparam int Q_DEPTH       = 2;
    localparam int Q_CNT_W       = $clog2(Q_DEPTH + 1);

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_EMIT = 1'b1
    } op_t;

    typedef enum logic {
        CFG_HAS_ALPHA = 1'b0,
        CFG_OUT_WIDTH = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        op_t                    op;
        logic [31:0]            pixel;
        logic [TAPS-1:0][15:0]  hw;
        logic [TAPS-1:0][15:0]  vw;
        logic [2:0]             closes;
    } item_t;

    typedef struct packed {
        logic [Q_CNT_W-1:0] count;
    } front_status_t;

    typedef struct packed {
        logic clearing;
        logic emitting;
    } back_status_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
            r = 32'sh7FFF_FFFF;
        else if (v < -64'sd2147483648)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

    // Half rounds up; negative and zero sums give level zero.
    function automatic logic [7:0] round_level(input logic signed [31:0] v);
        logic [32:0]       t;
        logic [32-W_FRAC:0] q;
        logic [7:0]        r;
        t = {1'b0, v} + 33'(1 << (W_FRAC - 1));
        q = t[32:W_FRAC];
        if (v <= 0)
            r = 8'd0;
        else if (q > (33 - W_FRAC)'(255))
            r = 8'hFF;
        else
            r = q[7:0];
        return r;
    endfunction

endpackage

>>> rtl/ssd_front.sv
// Front end: accepts requests and holds them in a short queue.
// Depends on ssd_pkg.
module ssd_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  ssd_pkg::item_t         item,
    input  logic                   hold,
    output ssd_pkg::item_t         q_item,
    output logic                   q_valid,
    input  logic                   q_pop,
    output ssd_pkg::front_status_t status
);
    import ssd_pkg::*;

    item_t               ent_reg [Q_DEPTH];
    logic                wr_ptr_reg;
    logic                rd_ptr_reg;
    logic [Q_CNT_W-1:0]  count_reg;
    logic                push;
    logic                pop;

    assign in_stall     = hold || (count_reg == Q_CNT_W'(Q_DEPTH));
    assign push         = in_valid && !in_stall;
    assign q_valid      = (count_reg != '0);
    assign pop          = q_pop && q_valid;
    assign q_item       = ent_reg[rd_ptr_reg];
    assign status.count = count_reg;

    always_ff @(posedge clk)
    begin
        if (push)
            ent_reg[wr_ptr_reg] <= item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end
endmodule

>>> rtl/ssd_back.sv
// Back end: horizontal lanes, banked column store and output register.
// Depends on ssd_pkg.
module ssd_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ssd_pkg::item_t        q_item,
    input  logic                  q_valid,
    output logic                  q_pop,
    input  logic                  has_alpha,
    input  logic [ssd_pkg::WID_W-1:0] out_width,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [31:0]           pixel_out,
    output logic                  row_last,
    output ssd_pkg::back_status_t status
);
    import ssd_pkg::*;

    typedef enum logic [6:0] {
        S_CLR  = 7'b0000001,
        S_IDLE = 7'b0000010,
        S_HACC = 7'b0000100,
        S_RD   = 7'b0001000,
        S_WR   = 7'b0010000,
        S_ERD  = 7'b0100000,
        S_EOUT = 7'b1000000
    } state_t;

    state_t                    state_reg, state_next;
    item_t                     item_reg;
    logic signed [31:0]        lanes_reg [TAPS][NCH];
    logic signed [31:0]        hsum [TAPS][NCH];
    logic signed [SH_W-1:0]    prod_reg [TAPS][NCH];
    logic signed [SH_W-1:0]    prod_next [TAPS][NCH];
    logic [ROW_W-1:0]          rd_data_reg [TAPS];
    logic [ROW_W-1:0]          wdata [TAPS];
    logic [TAPS-1:0]           we;
    logic                      re;
    logic [COL_W-1:0]          raddr;
    logic [COL_W-1:0]          waddr;
    logic [COL_W-1:0]          wcol_reg;
    logic [COL_W-1:0]          ecol_reg;
    logic [COL_W-1:0]          clr_reg;
    logic [TAP_W-1:0]          tap_reg;
    logic [2:0]                left_reg;
    logic                      out_valid_reg;
    logic [31:0]               pixel_reg;
    logic                      last_reg;
    logic [WID_W-1:0]          wid;
    logic [WID_W-1:0]          wcol_inc;
    logic [WID_W-1:0]          ecol_inc;
    logic                      load_out;
    logic [7:0]                lv [NCH];
    logic [7:0]                amax;
    logic [TAP_W-1:0]          tsel;

    // Out-of-range widths clamp into 1..MAX_OUT_WIDTH.
    always_comb
    begin
        if (out_width == '0)
            wid = WID_W'(1);
        else if (out_width > WID_W'(MAX_OUT_WIDTH))
            wid = WID_W'(MAX_OUT_WIDTH);
        else
            wid = out_width;
    end

    assign wcol_inc = {1'b0, wcol_reg} + 1'b1;
    assign ecol_inc = {1'b0, ecol_reg} + 1'b1;
    assign load_out = (state_reg == S_EOUT) && (!out_valid_reg || !out_stall);
    assign q_pop    = (state_reg == S_IDLE) && q_valid;

    always_comb
    begin
        for (int k = 0; k < TAPS; k++)
        begin
            for (int ch = 0; ch < NCH; ch++)
            begin
                hsum[k][ch] = sat32(64'(lanes_reg[k][ch])
                    + 64'($signed(item_reg.hw[k])
                    * $signed({1'b0, item_reg.pixel[8*ch +: 8]})));
            end
        end
    end

    // Bank b holds ring row b; its weight is the one of tap (b - ring_tap).
    always_comb
    begin
        tsel = '0;
        for (int b = 0; b < TAPS; b++)
        begin
            tsel = TAP_W'(b) - tap_reg;
            for (int ch = 0; ch < NCH; ch++)
            begin
                prod_next[b][ch] = SH_W'((PROD_W'(lanes_reg[0][ch])
                    * PROD_W'($signed(item_reg.vw[tsel]))) >>> W_FRAC);
            end
        end
    end

    always_comb
    begin
        amax = 8'd0;
        for (int ch = 0; ch < NCH; ch++)
        begin
            lv[ch] = round_level($signed(rd_data_reg[tap_reg][32*ch +: 32]));
            if (lv[ch] > amax)
                amax = lv[ch];
        end
    end

    always_comb
    begin
        re    = (state_reg == S_RD) || (state_reg == S_ERD);
        raddr = (state_reg == S_ERD) ? ecol_reg : wcol_reg;
        waddr = wcol_reg;
        if (state_reg == S_CLR)
            waddr = clr_reg;
        else if (state_reg == S_EOUT)
            waddr = ecol_reg;
        for (int b = 0; b < TAPS; b++)
        begin
            we[b]    = (state_reg == S_WR) || (state_reg == S_CLR)
                       || (load_out && (tap_reg == TAP_W'(b)));
            wdata[b] = '0;
            if (state_reg == S_WR)
            begin
                for (int ch = 0; ch < NCH; ch++)
                begin
                    wdata[b][32*ch +: 32] = sat32(
                        64'($signed(rd_data_reg[b][32*ch +: 32]))
                        + 64'(prod_reg[b][ch]));
                end
            end
        end
    end

    for (genvar b = 0; b < TAPS; b++)
    begin : g_bank
        logic [ROW_W-1:0] mem [MAX_OUT_WIDTH];

        always_ff @(posedge clk)
        begin
            if (we[b])
                mem[waddr] <= wdata[b];
            if (re)
                rd_data_reg[b] <= mem[raddr];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLR:
            begin
                if (clr_reg == COL_W'(MAX_OUT_WIDTH - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (q_valid)
                    state_next = (q_item.op == OP_EMIT) ? S_ERD : S_HACC;
            end
            S_HACC:
            begin
                state_next = (item_reg.closes == 3'd0) ? S_IDLE : S_RD;
            end
            S_RD:
            begin
                state_next = S_WR;
            end
            S_WR:
            begin
                if (wcol_inc >= wid || left_reg == 3'd1)
                    state_next = S_IDLE;
                else
                    state_next = S_RD;
            end
            S_ERD:
            begin
                state_next = S_EOUT;
            end
            S_EOUT:
            begin
                if (load_out)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            item_reg <= q_item;
        if (state_reg == S_RD)
            prod_reg <= prod_next;
        if (load_out)
        begin
            pixel_reg[23:0]  <= {lv[2], lv[1], lv[0]};
            pixel_reg[31:24] <= has_alpha ? amax : 8'hFF;
            last_reg         <= (ecol_inc >= wid);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_reg       <= '0;
            wcol_reg      <= '0;
            ecol_reg      <= '0;
            tap_reg       <= '0;
            left_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < TAPS; k++)
                for (int ch = 0; ch < NCH; ch++)
                    lanes_reg[k][ch] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLR)
                clr_reg <= clr_reg + 1'b1;
            if (state_reg == S_HACC)
            begin
                lanes_reg <= hsum;
                left_reg  <= item_reg.closes;
            end
            if (state_reg == S_WR)
            begin
                left_reg <= left_reg - 1'b1;
                if (wcol_inc >= wid)
                begin
                    wcol_reg <= '0;
                    for (int k = 0; k < TAPS; k++)
                        for (int ch = 0; ch < NCH; ch++)
                            lanes_reg[k][ch] <= '0;
                end
                else
                begin
                    wcol_reg <= wcol_inc[COL_W-1:0];
                    for (int k = 0; k < TAPS - 1; k++)
                        lanes_reg[k] <= lanes_reg[k+1];
                    for (int ch = 0; ch < NCH; ch++)
                        lanes_reg[TAPS-1][ch] <= '0;
                end
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
                if (ecol_inc >= wid)
                begin
                    ecol_reg <= '0;
                    tap_reg  <= tap_reg + 1'b1;
                end
                else
                begin
                    ecol_reg <= ecol_inc[COL_W-1:0];
                end
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign pixel_out       = pixel_reg;
    assign row_last        = last_reg;
    assign status.clearing = (state_reg == S_CLR);
    assign status.emitting = (state_reg == S_EOUT);
endmodule

>>> rtl/streaming_separable_downscaler_core.sv
// In the back end a push is added into the horizontal lanes, then each closed column takes a read
// and a write of the four tap banks (closes stop at the row end); an emit reads its column, then
// waits to load the output register while out_stall holds it. The back end takes the next request
// from the queue only when it is through with the last one.
// Reset: asynchronous, active low; afterwards a pass over every column clears the column store,
// during which in_stall is high and configuration writes are still taken.
`include "streaming_separable_downscaler_core_macros.svh"

module streaming_separable_downscaler_core (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic                      cfg_index,
    input  logic [ssd_pkg::WID_W-1:0] cfg_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      operation,
    input  logic [31:0]               pixel_in,
    input  logic signed [15:0]        hweight_0,
    input  logic signed [15:0]        hweight_1,
    input  logic signed [15:0]        hweight_2,
    input  logic signed [15:0]        hweight_3,
    input  logic signed [15:0]        vweight_0,
    input  logic signed [15:0]        vweight_1,
    input  logic signed [15:0]        vweight_2,
    input  logic signed [15:0]        vweight_3,
    input  logic [2:0]                columns_closed,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [31:0]               pixel_out,
    output logic                      row_last
);
    import ssd_pkg::*;

    logic              has_alpha_reg;
    logic [WID_W-1:0]  out_width_reg;
    item_t             item;
    item_t             q_item;
    logic              q_valid;
    logic              q_pop;
    front_status_t     fstat;
    back_status_t      bstat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            has_alpha_reg <= 1'b0;
            out_width_reg <= WID_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_HAS_ALPHA: has_alpha_reg <= cfg_data[0];
                CFG_OUT_WIDTH: out_width_reg <= cfg_data;
                default:       has_alpha_reg <= has_alpha_reg;
            endcase
        end
    end

    always_comb
    begin
        item.op     = op_t'(operation);
        item.pixel  = pixel_in;
        item.hw     = {hweight_3, hweight_2, hweight_1, hweight_0};
        item.vw     = {vweight_3, vweight_2, vweight_1, vweight_0};
        item.closes = columns_closed;
    end

    ssd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .item     (item),
        .hold     (bstat.clearing),
        .q_item   (q_item),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .status   (fstat)
    );

    ssd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_item    (q_item),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .has_alpha (has_alpha_reg),
        .out_width (out_width_reg),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .pixel_out (pixel_out),
        .row_last  (row_last),
        .status    (bstat)
    );

    `SSD_ASSERT_NEVER(a_queue_bound, clk, rst_n, fstat.count > Q_CNT_W'(Q_DEPTH), "queue overflow")
    `SSD_ASSERT_IMPLY(a_clear_stalls, clk, rst_n, bstat.clearing, in_stall && !q_pop, "request during clear")
    `SSD_ASSERT_IMPLY(a_clear_no_out, clk, rst_n, bstat.clearing, !out_valid && !bstat.emitting, "output during clear")
endmodule

>>> tb/sv/tb_top.sv
// Self-checking testbench for streaming_separable_downscaler_core.
// Depends on ssd_pkg and the RTL of the block; a built-in predictor of the
// lanes and column store works out every output pixel.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import ssd_pkg::*;

    localparam int LIMIT_CYCLES = 600000;
    localparam int SETTLE = 100;

    typedef struct {
        logic [31:0] pixel;
        logic        last;
    } out_pixel_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic cfg_index = 1'b0;
    logic [WID_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic operation = 1'b0;
    logic [31:0] pixel_in = '0;
    logic signed [15:0] hweight_0 = '0, hweight_1 = '0, hweight_2 = '0, hweight_3 = '0;
    logic signed [15:0] vweight_0 = '0, vweight_1 = '0, vweight_2 = '0, vweight_3 = '0;
    logic [2:0] columns_closed = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [31:0] pixel_out;
    logic row_last;

    streaming_separable_downscaler_core i_dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall),
        .operation(operation), .pixel_in(pixel_in),
        .hweight_0(hweight_0), .hweight_1(hweight_1),
        .hweight_2(hweight_2), .hweight_3(hweight_3),
        .vweight_0(vweight_0), .vweight_1(vweight_1),
        .vweight_2(vweight_2), .vweight_3(vweight_3),
        .columns_closed(columns_closed), .out_valid(out_valid),
        .out_stall(out_stall), .pixel_out(pixel_out), .row_last(row_last)
    );

    always #1 clk = ~clk;

    // Predictor state of the scaler.
    int          lanes [TAPS][NCH];
    int          col_store [MAX_OUT_WIDTH*TAPS*NCH];
    int unsigned write_col, emit_col, ring_tap;
    logic        alpha_on;
    int unsigned width_reg;
    out_pixel_t  expected_pixels [$];

    int unsigned cycles = 0;
    int unsigned errors = 0;
    int unsigned sender_idle = 0;
    int unsigned receiver_idle = 0;

    function automatic int clamp32(longint v);
        if (v > 64'sd2147483647)
            return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648)
            return 32'sh8000_0000;
        return int'(v);
    endfunction

    function automatic int unsigned active_width();
        if (width_reg == 0)
            return 1;
        if (width_reg > MAX_OUT_WIDTH)
            return MAX_OUT_WIDTH;
        return width_reg;
    endfunction

    function automatic logic [7:0] level_of(int v);
        longint q;
        if (v <= 0)
            return 8'd0;
        q = (longint'(v) + (longint'(1) << (W_FRAC - 1))) >>> W_FRAC;
        return (q > 255) ? 8'hFF : q[7:0];
    endfunction

    function automatic void accumulate_push(item_t it);
        int unsigned wd, col, idx;
        longint prod;
        int c;
        wd = active_width();
        for (int ch = 0; ch < NCH; ch++)
        begin
            c = int'(it.pixel[8*ch +: 8]);
            for (int k = 0; k < TAPS; k++)
                lanes[k][ch] = clamp32(longint'(lanes[k][ch]) +
                                       longint'($signed(it.hw[k])) * c);
        end
        for (int n = 0; n < it.closes; n++)
        begin
            col = write_col % MAX_OUT_WIDTH;
            for (int t = 0; t < TAPS; t++)
                for (int ch = 0; ch < NCH; ch++)
                begin
                    idx = (col * TAPS + ((ring_tap + t) & 3)) * NCH + ch;
                    // Arithmetic shift of a signed product rounds toward minus infinity.
                    prod = (longint'(lanes[0][ch]) * longint'($signed(it.vw[t]))) >>> W_FRAC;
                    col_store[idx] = clamp32(longint'(col_store[idx]) + prod);
                end
            for (int k = 0; k < TAPS - 1; k++)
                lanes[k] = lanes[k+1];
            for (int ch = 0; ch < NCH; ch++)
                lanes[TAPS-1][ch] = 0;
            write_col = col + 1;
            if (write_col >= wd)
            begin
                for (int k = 0; k < TAPS; k++)
                    for (int ch = 0; ch < NCH; ch++)
                        lanes[k][ch] = 0;
                write_col = 0;
                break;
            end
        end
    endfunction

    function automatic out_pixel_t emit_pixel();
        out_pixel_t r;
        int unsigned col, base;
        logic [7:0] lv, mx;
        col = emit_col % MAX_OUT_WIDTH;
        base = (col * TAPS + (ring_tap & 3)) * NCH;
        mx = 8'd0;
        for (int ch = 0; ch < NCH; ch++)
        begin
            lv = level_of(col_store[base + ch]);
            col_store[base + ch] = 0;
            if (lv > mx)
                mx = lv;
            r.pixel[8*ch +: 8] = lv;
        end
        r.pixel[31:24] = alpha_on ? mx : 8'hFF;
        r.last = (col + 1 >= active_width());
        if (r.last)
        begin
            emit_col = 0;
            ring_tap = (ring_tap + 1) & 3;
        end
        else
            emit_col = col + 1;
        return r;
    endfunction

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(negedge clk)
        out_stall <= ($urandom_range(99) < receiver_idle);

    // Compares every accepted output pixel with the oldest prediction.
    always @(posedge clk)
    begin
        out_pixel_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_pixels.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected output pixel %h row_last %b", pixel_out, row_last);
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (pixel_out !== want.pixel || row_last !== want.last)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: expected pixel %h last %b, got pixel %h last %b",
                                 want.pixel, want.last, pixel_out, row_last);
                end
            end
        end
    end

    task automatic write_reg(cfg_idx_t idx, int unsigned value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[WID_W-1:0];
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_HAS_ALPHA)
            alpha_on = value[0];
        else
            width_reg = value & 32'h1FFF;
    endtask

    // Sends one request and updates the prediction once it is accepted.
    task automatic send_request(item_t it);
        forever
        begin
            @(negedge clk);
            if ($urandom_range(99) < sender_idle)
                in_valid <= 1'b0;
            else
                break;
        end
        in_valid <= 1'b1;
        operation <= it.op;
        pixel_in <= it.pixel;
        hweight_0 <= it.hw[0];
        hweight_1 <= it.hw[1];
        hweight_2 <= it.hw[2];
        hweight_3 <= it.hw[3];
        vweight_0 <= it.vw[0];
        vweight_1 <= it.vw[1];
        vweight_2 <= it.vw[2];
        vweight_3 <= it.vw[3];
        columns_closed <= it.closes;
        do
            @(posedge clk);
        while (in_stall);
        if (it.op == OP_EMIT)
            expected_pixels.push_back(emit_pixel());
        else
            accumulate_push(it);
    endtask

    // Lets the block go idle; pushes give no output, so some slack follows.
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    function automatic item_t make_push(logic [31:0] px, logic [15:0] h, logic [15:0] v,
                                        logic [2:0] closes);
        item_t it;
        it.op = OP_PUSH;
        it.pixel = px;
        for (int k = 0; k < TAPS; k++)
        begin
            it.hw[k] = h;
            it.vw[k] = v;
        end
        it.closes = closes;
        return it;
    endfunction

    function automatic item_t make_emit();
        item_t it;
        it = make_push($urandom, 16'($urandom), 16'($urandom), 3'($urandom));
        it.op = OP_EMIT;
        return it;
    endfunction

    function automatic logic [15:0] random_weight();
        if ($urandom_range(9) == 0)
            return 16'($urandom);
        return 16'($urandom_range(16384));
    endfunction

    function automatic item_t random_item();
        item_t it;
        int unsigned r;
        if ($urandom_range(99) < 40)
            return make_emit();
        it = make_push($urandom, 16'd0, 16'd0, 3'd0);
        for (int k = 0; k < TAPS; k++)
        begin
            it.hw[k] = random_weight();
            it.vw[k] = random_weight();
        end
        r = $urandom_range(99);
        it.closes = (r < 50) ? 3'd0 : (r < 80) ? 3'd1 : (r < 95) ? 3'($urandom_range(2, 4))
                  : 3'($urandom_range(5, 7));
        return it;
    endfunction

    task automatic test_extremes();
        write_reg(CFG_HAS_ALPHA, 1);
        write_reg(CFG_OUT_WIDTH, 4);
        send_request(make_push(32'hFFFF_FFFF, 16'h7FFF, 16'h7FFF, 3'd0));
        send_request(make_push(32'hFFFF_FFFF, 16'h7FFF, 16'h7FFF, 3'd1));
        send_request(make_push(32'h0000_0000, 16'h8000, 16'h8000, 3'd1));
        send_request(make_push(32'hFF00_FF00, 16'h8000, 16'h7FFF, 3'd2));
        send_request(make_push(32'h80FF_017F, 16'h4000, 16'h4000, 3'd0));
        for (int i = 0; i < 5; i++)
            send_request(make_emit());
        drain();
        // Drive large lane sums and negative vertical weights into the store.
        for (int i = 0; i < 3; i++)
            send_request(make_push(32'hFFFF_FFFF, 16'h7FFF, 16'h8000, 3'd0));
        send_request(make_push(32'hFFFF_FFFF, 16'h7FFF, 16'h8000, 3'd4));
        send_request(make_push(32'h1234_5678, 16'h2000, 16'h6000, 3'd4));
        for (int i = 0; i < 4; i++)
            send_request(make_emit());
        drain();
    endtask

    task automatic test_row_control();
        // More closes than lanes, and closes past the row end.
        write_reg(CFG_HAS_ALPHA, 0);
        write_reg(CFG_OUT_WIDTH, 8);
        send_request(make_push(32'hC0A0_8060, 16'h4000, 16'h4000, 3'd7));
        send_request(make_push(32'h3020_1000, 16'h3000, 16'h1000, 3'd7));
        drain();
        // The width is lowered below the current write and emit columns.
        send_request(make_push(32'h7F7F_7F7F, 16'h4000, 16'h4000, 3'd5));
        for (int i = 0; i < 5; i++)
            send_request(make_emit());
        drain();
        write_reg(CFG_OUT_WIDTH, 2);
        send_request(make_push(32'hFFFF_FFFF, 16'h4000, 16'h4000, 3'd1));
        send_request(make_emit());
        send_request(make_emit());
        drain();
        // Out-of-range widths and the largest legal width.
        write_reg(CFG_OUT_WIDTH, 0);
        send_request(make_push(32'h5050_5050, 16'h4000, 16'h4000, 3'd2));
        send_request(make_emit());
        drain();
        write_reg(CFG_OUT_WIDTH, 8191);
        send_request(make_push(32'h9090_9090, 16'h4000, 16'h4000, 3'd3));
        send_request(make_emit());
        drain();
        write_reg(CFG_OUT_WIDTH, MAX_OUT_WIDTH);
        send_request(make_push(32'hA0B0_C0D0, 16'h4000, 16'h4000, 3'd3));
        send_request(make_emit());
        drain();
    endtask

    task automatic test_random(int unsigned in_idle, int unsigned out_idle, logic alpha,
                               int unsigned wd, bit pause);
        sender_idle = in_idle;
        receiver_idle = out_idle;
        write_reg(CFG_HAS_ALPHA, alpha);
        write_reg(CFG_OUT_WIDTH, wd);
        for (int i = 0; i < 245; i++)
        begin
            if (pause && i == 120)
                drain();
            send_request(random_item());
        end
        drain();
    endtask

    initial
    begin
        for (int k = 0; k < TAPS; k++)
            for (int ch = 0; ch < NCH; ch++)
                lanes[k][ch] = 0;
        foreach (col_store[i])
            col_store[i] = 0;
        write_col = 0;
        emit_col = 0;
        ring_tap = 0;
        alpha_on = 1'b0;
        width_reg = 1;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_extremes();
        test_row_control();
        test_random(30, 88, 1'b0, $urandom_range(1, 6), 1'b1);
        test_random(88, 30, 1'b1, $urandom_range(7, 40), 1'b0);
        test_random(0, 0, 1'b1, 1, 1'b0);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
